// ----- hdl/lmt_pkg.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing package
// Shared field widths, mode codes, register indexes and the STAT condition
// function used by the LCD mode timing block and its checker.
// ----------------------------------------------------------------------------
package lmt_pkg;

   // Field widths of the request, response and register port.
   localparam int DOTS_W     = 8;
   localparam int LINE_W     = 8;
   localparam int EN_W       = 4;
   localparam int SC_W       = 4;
   localparam int MODE_W     = 2;
   localparam int EVENT_W    = 9;
   localparam int BASE_W     = 9;
   localparam int PER_W      = 5;
   localparam int CAP_W      = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // LCD mode codes as software reads them.
   localparam logic [MODE_W-1:0] MODE_HBLANK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_VBLANK = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OAM    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_DRAW   = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_BASE       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DOTS_PER_SPRITE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_CAP        = 2'd2;

   // Register reset values.
   localparam logic [BASE_W-1:0] BASE_RESET = 9'd172;
   localparam logic [PER_W-1:0]  PER_RESET  = 5'd8;
   localparam logic [CAP_W-1:0]  CAP_RESET  = 9'd289;

   // Fixed timing constants.
   localparam logic [LINE_W-1:0]  LAST_LINE   = 8'd153;
   localparam logic [SC_W-1:0]    MAX_SPRITES = 4'd10;
   localparam logic [EVENT_W-1:0] EVENT_MAX   = 9'd511;

   // STAT source bit positions.
   localparam int EN_HBLANK = 0;
   localparam int EN_VBLANK = 1;
   localparam int EN_OAM    = 2;
   localparam int EN_LYC    = 3;

   // Combined STAT condition for a given mode and line.
   function automatic logic stat_sig(input logic [MODE_W-1:0] mode,
                                     input logic [LINE_W-1:0] line,
                                     input logic [LINE_W-1:0] lyc,
                                     input logic [EN_W-1:0]   en);
      return (en[EN_HBLANK] && (mode == MODE_HBLANK)) ||
             (en[EN_VBLANK] && (mode == MODE_VBLANK)) ||
             (en[EN_OAM]    && (mode == MODE_OAM))    ||
             (en[EN_LYC]    && (line == lyc));
   endfunction

endpackage

// ----- hdl/lmt_if.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing channels
// Valid/ready channels for the tick request word and the timing response word.
// ----------------------------------------------------------------------------
interface lmt_req_if;
   logic                      valid;
   logic                      ready;
   logic [lmt_pkg::DOTS_W-1:0] dots;
   logic                      lcd_on;
   logic [lmt_pkg::LINE_W-1:0] lyc;
   logic [lmt_pkg::EN_W-1:0]   stat_enables;
   logic [lmt_pkg::SC_W-1:0]   sprite_count;

   modport source (output valid, dots, lcd_on, lyc, stat_enables, sprite_count,
                   input ready);
   modport sink   (input valid, dots, lcd_on, lyc, stat_enables, sprite_count,
                   output ready);
endinterface

interface lmt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lmt_pkg::LINE_W-1:0]  line;
   logic [lmt_pkg::MODE_W-1:0]  mode;
   logic                        coincidence;
   logic                        stat_line;
   logic                        stat_irq;
   logic                        vblank_irq;
   logic                        hblank_entered;
   logic                        frame_done;
   logic [lmt_pkg::EVENT_W-1:0] dots_to_event;

   modport source (output valid, line, mode, coincidence, stat_line, stat_irq,
                   vblank_irq, hblank_entered, frame_done, dots_to_event,
                   input ready);
   modport sink   (input valid, line, mode, coincidence, stat_line, stat_irq,
                   vblank_irq, hblank_entered, frame_done, dots_to_event,
                   output ready);
endinterface

// ----- hdl/lcd_mode_timing_stat_irq.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing with STAT interrupt
// Sequencer that advances LCD line and mode timing by one tick word at a time.
// ----------------------------------------------------------------------------
// A tick word passes from acceptance through the start, prepare and step
// states, and then the finish state loads the response register; a
// display-off word goes from start straight to finish. The sequencer runs
// one mode change per cycle through a single shared subtractor and then
// reuses it for the dots-to-event count.
// The request side is busy while a word is in work; a finished response waits
// in its own register, so the next word is taken while it is still unread.
module lcd_mode_timing_stat_irq #(
   parameter int LINE_DOTS     = 456,
   parameter int OAM_DOTS      = 80,
   parameter int VISIBLE_LINES = 144
) (
   input  logic                              clock,
   input  logic                              reset,
   lmt_req_if.sink                           req_ch,
   lmt_rsp_if.source                         rsp_ch,
   input  logic                              csr_we,
   input  logic [lmt_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lmt_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import lmt_pkg::*;

   // Longest phase is a line or a capped draw phase; a tick adds under 256.
   localparam int MAX_DUR = (LINE_DOTS > 511) ? LINE_DOTS : 511;
   localparam int DOT_W   = $clog2(MAX_DUR + 256);
   localparam int USED_W  = DOT_W + 1;
   localparam logic [EVENT_W-1:0] OFF_EVENT =
      (LINE_DOTS > 511) ? EVENT_MAX : EVENT_W'(LINE_DOTS);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_START  = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_STEP   = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]          state_ff, state_in;

   // Registers.
   logic [BASE_W-1:0]   base_ff;
   logic [PER_W-1:0]    per_ff;
   logic [CAP_W-1:0]    cap_ff;

   // Latched request word.
   logic [DOTS_W-1:0]   dots_ff;
   logic                on_ff;
   logic [LINE_W-1:0]   lyc_ff;
   logic [EN_W-1:0]     en_ff;
   logic [SC_W-1:0]     sc_ff;

   // Timing state.
   logic [DOT_W-1:0]    dot_ff, dot_in;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [LINE_W-1:0]   line_ff, line_in;
   logic [LINE_W-1:0]   vrow_ff, vrow_in;
   logic [BASE_W-1:0]   draw_len_ff, draw_len_in;
   logic [DOT_W-1:0]    hb_len_ff, hb_len_in;
   logic                was_on_ff, was_on_in;
   logic                level_ff, level_in;

   // Per-word working values.
   logic [PER_W+SC_W-1:0] prod_ff, prod_in;
   logic [BASE_W-1:0]     len_cand_ff, len_cand_in;
   logic [DOT_W-1:0]      hb_cand_ff, hb_cand_in;
   logic                  sirq_ff, sirq_in;
   logic                  virq_ff, virq_in;
   logic                  hb_ff, hb_in;
   logic                  fdone_ff, fdone_in;

   // Response register.
   logic                  rsp_valid_ff;
   logic                  rsp_load;
   logic [LINE_W-1:0]     rsp_line_ff;
   logic [MODE_W-1:0]     rsp_mode_ff;
   logic                  rsp_coin_ff;
   logic                  rsp_stat_ff;
   logic                  rsp_sirq_ff;
   logic                  rsp_virq_ff;
   logic                  rsp_hb_ff;
   logic                  rsp_fdone_ff;
   logic [EVENT_W-1:0]    rsp_event_ff;

   // Shared unit operands and draw-length arithmetic.
   logic [DOT_W-1:0]      dur;
   logic [DOT_W-1:0]      sub_a, sub_b, sub_diff;
   logic                  sub_borrow;
   logic [SC_W-1:0]       sc_cap;
   logic [BASE_W:0]       len_sum;
   logic [BASE_W-1:0]     len_clip;
   logic [USED_W-1:0]     used;
   logic [EVENT_W-1:0]    event_sat;
   logic [LINE_W-1:0]     line_next;
   logic [LINE_W-1:0]     vrow_next;
   logic                  sig_a, sig_b;

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Register writes; an index past the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= BASE_RESET;
         per_ff  <= PER_RESET;
         cap_ff  <= CAP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DRAW_BASE:       base_ff <= csr_wdata[BASE_W-1:0];
            CSR_DOTS_PER_SPRITE: per_ff  <= csr_wdata[PER_W-1:0];
            CSR_DRAW_CAP:        cap_ff  <= csr_wdata[CAP_W-1:0];
            default:             ;
         endcase
      end
   end

   // Capture the request word.
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         dots_ff <= req_ch.dots;
         on_ff   <= req_ch.lcd_on;
         lyc_ff  <= req_ch.lyc;
         en_ff   <= req_ch.stat_enables;
         sc_ff   <= req_ch.sprite_count;
      end
   end

   // Phase length of the current mode.
   always_comb begin
      case (mode_ff)
         MODE_OAM:    dur = DOT_W'(OAM_DOTS);
         MODE_DRAW:   dur = DOT_W'(draw_len_ff);
         MODE_HBLANK: dur = hb_len_ff;
         default:     dur = DOT_W'(LINE_DOTS);
      endcase
   end

   // The unit tests counter against phase while stepping, then the reverse.
   assign sub_a = (state_ff == ST_FINISH) ? dur : dot_ff;
   assign sub_b = (state_ff == ST_FINISH) ? dot_ff : dur;

   lmt_sub_unit #(
      .WIDTH (DOT_W)
   ) u_sub (
      .a      (sub_a),
      .b      (sub_b),
      .diff   (sub_diff),
      .borrow (sub_borrow)
   );

   // Draw and hblank lengths for the line being scanned.
   assign sc_cap   = (sc_ff > MAX_SPRITES) ? MAX_SPRITES : sc_ff;
   assign len_sum  = {1'b0, base_ff} + (BASE_W+1)'(prod_ff);
   assign len_clip = (len_sum > {1'b0, cap_ff}) ? cap_ff : len_sum[BASE_W-1:0];
   assign used     = USED_W'(OAM_DOTS) + USED_W'(len_clip);

   assign line_next = line_ff + 8'd1;
   assign vrow_next = vrow_ff + 8'd1;

   assign event_sat = (sub_diff > DOT_W'(EVENT_MAX)) ? EVENT_MAX : sub_diff[EVENT_W-1:0];

   // Sequencer: one mode change per cycle in the step state.
   always_comb begin
      state_in    = state_ff;
      dot_in      = dot_ff;
      mode_in     = mode_ff;
      line_in     = line_ff;
      vrow_in     = vrow_ff;
      draw_len_in = draw_len_ff;
      hb_len_in   = hb_len_ff;
      was_on_in   = was_on_ff;
      level_in    = level_ff;
      prod_in     = prod_ff;
      len_cand_in = len_clip;
      hb_cand_in  = hb_cand_ff;
      sirq_in     = sirq_ff;
      virq_in     = virq_ff;
      hb_in       = hb_ff;
      fdone_in    = fdone_ff;
      rsp_load    = 1'b0;
      sig_a       = 1'b0;
      sig_b       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = ST_START;
            end
         end

         ST_START: begin
            sirq_in  = 1'b0;
            virq_in  = 1'b0;
            hb_in    = 1'b0;
            fdone_in = 1'b0;
            prod_in  = sc_cap * per_ff;
            if (!on_ff) begin
               // Display off: timing parks at line 0 in hblank.
               if (was_on_ff) begin
                  was_on_in = 1'b0;
                  line_in   = '0;
                  mode_in   = MODE_HBLANK;
                  dot_in    = '0;
                  level_in  = 1'b0;
               end
               state_in = ST_FINISH;
            end else begin
               // Display turning on restarts the line in OAM scan.
               if (was_on_ff) begin
                  dot_in = dot_ff + DOT_W'(dots_ff);
               end else begin
                  was_on_in = 1'b1;
                  mode_in   = MODE_OAM;
                  line_in   = '0;
                  dot_in    = DOT_W'(dots_ff);
               end
               state_in = ST_PREP;
            end
         end

         ST_PREP: begin
            len_cand_in = len_clip;
            hb_cand_in  = (used >= USED_W'(LINE_DOTS)) ? DOT_W'(1) :
                          DOT_W'(USED_W'(LINE_DOTS) - used);
            state_in    = ST_STEP;
         end

         ST_STEP: begin
            if (sub_borrow) begin
               state_in = ST_FINISH;
            end else begin
               dot_in = sub_diff;
               case (mode_ff)
                  MODE_OAM: begin
                     mode_in     = MODE_DRAW;
                     draw_len_in = len_cand_ff;
                     hb_len_in   = hb_cand_ff;
                     sig_a       = stat_sig(MODE_DRAW, line_ff, lyc_ff, en_ff);
                     sirq_in     = sirq_ff | (sig_a & ~level_ff);
                     level_in    = sig_a;
                  end
                  MODE_DRAW: begin
                     mode_in  = MODE_HBLANK;
                     hb_in    = 1'b1;
                     sig_a    = stat_sig(MODE_HBLANK, line_ff, lyc_ff, en_ff);
                     sirq_in  = sirq_ff | (sig_a & ~level_ff);
                     level_in = sig_a;
                  end
                  MODE_HBLANK: begin
                     line_in = line_next;
                     if (line_next >= LINE_W'(VISIBLE_LINES)) begin
                        mode_in  = MODE_VBLANK;
                        vrow_in  = LINE_W'(VISIBLE_LINES);
                        virq_in  = 1'b1;
                        fdone_in = 1'b1;
                        sig_a    = stat_sig(MODE_VBLANK, line_next, lyc_ff, en_ff);
                     end else begin
                        mode_in = MODE_OAM;
                        sig_a   = stat_sig(MODE_OAM, line_next, lyc_ff, en_ff);
                     end
                     sirq_in  = sirq_ff | (sig_a & ~level_ff);
                     level_in = sig_a;
                  end
                  default: begin
                     vrow_in = vrow_next;
                     if (vrow_next > LAST_LINE) begin
                        line_in  = '0;
                        mode_in  = MODE_OAM;
                        sig_a    = stat_sig(MODE_OAM, '0, lyc_ff, en_ff);
                        sirq_in  = sirq_ff | (sig_a & ~level_ff);
                        level_in = sig_a;
                     end else if (vrow_next == LAST_LINE) begin
                        // The STAT check sees the last line as 153 and then as 0; the line reads as 0.
                        line_in  = '0;
                        sig_a    = stat_sig(MODE_VBLANK, LAST_LINE, lyc_ff, en_ff);
                        sig_b    = stat_sig(MODE_VBLANK, '0, lyc_ff, en_ff);
                        sirq_in  = sirq_ff | (sig_a & ~level_ff) | (sig_b & ~sig_a);
                        level_in = sig_b;
                     end else begin
                        line_in  = vrow_next;
                        sig_a    = stat_sig(MODE_VBLANK, vrow_next, lyc_ff, en_ff);
                        sirq_in  = sirq_ff | (sig_a & ~level_ff);
                        level_in = sig_a;
                     end
                  end
               endcase
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer and timing state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         dot_ff      <= '0;
         mode_ff     <= MODE_OAM;
         line_ff     <= '0;
         vrow_ff     <= '0;
         draw_len_ff <= '0;
         hb_len_ff   <= DOT_W'(LINE_DOTS - OAM_DOTS);
         was_on_ff   <= 1'b0;
         level_ff    <= 1'b0;
         sirq_ff     <= 1'b0;
         virq_ff     <= 1'b0;
         hb_ff       <= 1'b0;
         fdone_ff    <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dot_ff      <= dot_in;
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         vrow_ff     <= vrow_in;
         draw_len_ff <= draw_len_in;
         hb_len_ff   <= hb_len_in;
         was_on_ff   <= was_on_in;
         level_ff    <= level_in;
         sirq_ff     <= sirq_in;
         virq_ff     <= virq_in;
         hb_ff       <= hb_in;
         fdone_ff    <= fdone_in;
      end
   end

   // Working values carry no control meaning.
   always_ff @(posedge clock) begin
      prod_ff     <= prod_in;
      len_cand_ff <= len_cand_in;
      hb_cand_ff  <= hb_cand_in;
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response word.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (!on_ff) begin
            rsp_line_ff  <= '0;
            rsp_mode_ff  <= MODE_HBLANK;
            rsp_coin_ff  <= (lyc_ff == '0);
            rsp_stat_ff  <= 1'b0;
            rsp_sirq_ff  <= 1'b0;
            rsp_virq_ff  <= 1'b0;
            rsp_hb_ff    <= 1'b0;
            rsp_fdone_ff <= 1'b0;
            rsp_event_ff <= OFF_EVENT;
         end else begin
            rsp_line_ff  <= line_ff;
            rsp_mode_ff  <= mode_ff;
            rsp_coin_ff  <= (line_ff == lyc_ff);
            rsp_stat_ff  <= level_ff;
            rsp_sirq_ff  <= sirq_ff;
            rsp_virq_ff  <= virq_ff;
            rsp_hb_ff    <= hb_ff;
            rsp_fdone_ff <= fdone_ff;
            rsp_event_ff <= event_sat;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.line           = rsp_line_ff;
   assign rsp_ch.mode           = rsp_mode_ff;
   assign rsp_ch.coincidence    = rsp_coin_ff;
   assign rsp_ch.stat_line      = rsp_stat_ff;
   assign rsp_ch.stat_irq       = rsp_sirq_ff;
   assign rsp_ch.vblank_irq     = rsp_virq_ff;
   assign rsp_ch.hblank_entered = rsp_hb_ff;
   assign rsp_ch.frame_done     = rsp_fdone_ff;
   assign rsp_ch.dots_to_event  = rsp_event_ff;

endmodule

// ----- hdl/lmt_sub_unit.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing subtract unit
// Shared subtractor with borrow: compares the dot counter against a phase
// length and gives the remainder, or gives the dots left to the next event.
// ----------------------------------------------------------------------------
module lmt_sub_unit #(
   parameter int WIDTH = 10
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] diff,
   output logic             borrow
);

   logic [WIDTH:0] full;

   // One extra bit catches the borrow when b exceeds a.
   assign full   = {1'b0, a} - {1'b0, b};
   assign diff   = full[WIDTH-1:0];
   assign borrow = full[WIDTH];

endmodule

// ----- hdl/lmt_checker.sv -----
// ----------------------------------------------------------------------------
// LCD mode timing checker
// Port-level assertions on the LCD mode timing block, attached by bind.
// ----------------------------------------------------------------------------
module lmt_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lmt_pkg::MODE_W-1:0]   rsp_mode,
   input logic                         rsp_vblank_irq,
   input logic                         rsp_frame_done,
   input logic [lmt_pkg::EVENT_W-1:0]  rsp_dots_to_event
);
   import lmt_pkg::*;

   // A response word stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response word dropped before it was taken");

   // The block works on one word at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a word is still in work");

   // There is always at least one dot to the next mode change.
   a_event_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_dots_to_event != '0)
      else $error("dots to event is zero");

   // Vblank entry marks a frame and a tick cannot leave vblank again.
   a_vblank_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vblank_irq |-> rsp_frame_done && (rsp_mode == MODE_VBLANK))
      else $error("vblank entry without frame done or vblank mode");

endmodule

bind lcd_mode_timing_stat_irq lmt_checker u_lmt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_mode          (rsp_ch.mode),
   .rsp_vblank_irq    (rsp_ch.vblank_irq),
   .rsp_frame_done    (rsp_ch.frame_done),
   .rsp_dots_to_event (rsp_ch.dots_to_event)
);
